>>> rtl/tidt_pkg.sv
// ----------------------------------------------------------------------------
// tidt_pkg
// shared types and constants of the transaction id tracker
// ----------------------------------------------------------------------------
package tidt_pkg;

	localparam int ID_W            = 32;
	localparam int TYPE_W          = 8;
	localparam int ENTRY_W         = ID_W + TYPE_W;
	localparam int TABLE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_VALIDATE = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_LOOKUP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOPEND = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

endpackage

>>> rtl/tidt_ram.sv
// ----------------------------------------------------------------------------
// tidt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tidt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/transaction_id_tracker.sv
// ----------------------------------------------------------------------------
// transaction_id_tracker
// table of pending transactions (id, message type) with id allocation
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_*      in   tuser: operation[1:0]; tdata: trans_id[31:0], msg_type[39:32]
// m_*      out  tdata: id_out[31:0], status[33:32], is_active[34],
//               type_matches[35], zero[39:36]
// cfg_*    in   data: id_seed[31:0]
//
// one sweep of the table ram reads one slot a cycle
// validate, remove, lookup: one sweep of the table from accept to result
// add: one sweep per candidate probed, 1 to TABLE_DEPTH candidates
// reset clears the valid bits at once, no clearing pass
// a result waits in the output register; the next word is taken once the
// sequencer is back in idle
// ----------------------------------------------------------------------------
module transaction_id_tracker import tidt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,   // operation[1:0]
	input  logic [39:0]         s_tdata,   // trans_id[31:0], msg_type[39:32]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // id_out[31:0], status[33:32],
	                                       // is_active[34], type_matches[35]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ID_W-1:0]     cfg_data   // id_seed[31:0]
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DONE
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [ID_W-1:0]      key_q;
	logic [TYPE_W-1:0]    type_q;
	logic [ID_W-1:0]      cand_q;
	logic [CW-1:0]        cnt_q;
	logic                 chk_s1;
	logic [IW-1:0]        idx_s1;
	logic                 hit_q;
	logic                 match_q;
	logic [IW-1:0]        slot_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [ID_W-1:0]      out_id_q;
	status_t              out_status_q;
	logic                 out_active_q;
	logic                 out_match_q;
	logic                 out_valid_q;

	logic                 issue;
	logic [IW-1:0]        raddr;
	logic [ENTRY_W-1:0]   rdata;
	logic [ID_W-1:0]      rd_id;
	logic [TYPE_W-1:0]    rd_type;
	logic [ID_W-1:0]      key;
	logic                 cmp_hit;
	logic                 out_free;
	logic                 ram_we;

	assign issue    = (cnt_q != CW'(TABLE_DEPTH));
	assign raddr    = issue ? cnt_q[IW-1:0] : '0;
	assign rd_id    = rdata[ID_W-1:0];
	assign rd_type  = rdata[ENTRY_W-1:ID_W];
	assign key      = (op_q == OP_ADD) ? cand_q : key_q;
	assign cmp_hit  = chk_s1 && valid_q[idx_s1] && (rd_id == key);
	assign out_free = !out_valid_q || m_tready;
	assign ram_we   = (state_q == S_DONE) && out_free && (op_q == OP_ADD)
		&& free_found_q && !hit_q;

	tidt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_q),
		.wdata({type_q, cand_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ADD;
			key_q        <= '0;
			type_q       <= '0;
			cand_q       <= '0;
			cnt_q        <= '0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			hit_q        <= 1'b0;
			match_q      <= 1'b0;
			slot_q       <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			valid_q      <= '0;
			out_id_q     <= '0;
			out_status_q <= STAT_OK;
			out_active_q <= 1'b0;
			out_match_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						cand_q <= cfg_data;
					end
					if (s_tvalid) begin
						op_q         <= op_t'(s_tuser);
						key_q        <= s_tdata[ID_W-1:0];
						type_q       <= s_tdata[ENTRY_W-1:ID_W];
						cnt_q        <= '0;
						chk_s1       <= 1'b0;
						hit_q        <= 1'b0;
						match_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (issue) begin
						cnt_q  <= cnt_q + CW'(1);
						chk_s1 <= 1'b1;
						idx_s1 <= cnt_q[IW-1:0];
					end else begin
						chk_s1 <= 1'b0;
					end
					if (cmp_hit && !hit_q) begin
						hit_q   <= 1'b1;
						slot_q  <= idx_s1;
						match_q <= (rd_type == type_q);
					end
					if (chk_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_s1;
					end
					if (!issue && !chk_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_id_q     <= key_q;
						out_status_q <= STAT_OK;
						out_active_q <= hit_q;
						out_match_q  <= hit_q && match_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
						unique case (op_q)
							OP_ADD: begin
								out_active_q <= 1'b0;
								out_match_q  <= 1'b0;
								if (!free_found_q) begin
									out_id_q     <= '0;
									out_status_q <= STAT_FULL;
								end else if (hit_q) begin
									// candidate taken, probe the next one
									cand_q      <= cand_q + ID_W'(1);
									hit_q       <= 1'b0;
									cnt_q       <= '0;
									chk_s1      <= 1'b0;
									out_valid_q <= 1'b0;
									state_q     <= S_SWEEP;
								end else begin
									valid_q[free_q] <= 1'b1;
									out_id_q        <= cand_q;
								end
							end
							OP_VALIDATE: begin
								if (hit_q && match_q) begin
									valid_q[slot_q] <= 1'b0;
								end else begin
									out_status_q <= STAT_NOPEND;
								end
							end
							OP_REMOVE: begin
								if (hit_q) begin
									valid_q[slot_q] <= 1'b0;
								end
							end
							OP_LOOKUP: begin
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'b0000, out_match_q, out_active_q, out_status_q, out_id_q};

endmodule

>>> rtl/tidt_chk.sv
// ----------------------------------------------------------------------------
// tidt_chk
// port level checks of the transaction id tracker, bound to the top level
// ----------------------------------------------------------------------------
module tidt_chk import tidt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[33:32] == STAT_OK || m_tdata[33:32] == STAT_NOPEND
			|| m_tdata[33:32] == STAT_FULL))
		else $error("undefined status code");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == STAT_FULL
			|-> m_tdata[31:0] == 32'd0 && !m_tdata[34] && !m_tdata[35])
		else $error("full result carries id or flags");

	a_match_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> m_tdata[34])
		else $error("type match on an inactive id");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

endmodule

bind transaction_id_tracker tidt_chk u_tidt_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

>>> tb/sv/transaction_id_tracker_tb.sv
// ----------------------------------------------------------------------------
// transaction_id_tracker_tb
// Self-checking bench for the transaction id tracker. A short list of directed
// words covers empty-table lookups, allocation from the reset seed, type
// mismatches on validate, filling the table and the full flag. Random words
// then run in phases with different id seeds, including both ends of the id
// range, so allocation wraps past the top. Most random words aim at held ids
// and their stored types. Each accepted word is run through a local copy of
// the table, and every result word is compared field by field. The sender
// idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module transaction_id_tracker_tb;
	import tidt_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam int DIR_ROWS    = 15;
	localparam int RAND_WORDS  = 400;
	localparam int PHASES      = 5;

	typedef struct packed {
		logic [ID_W-1:0] id_out;
		status_t         status;
		logic            id_active;
		logic            type_hit;
	} track_result_t;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [TYPE_W-1:0] ty;
		int unsigned       reps;
		logic              typed;
		track_result_t     lit;
	} stim_row_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [1:0]        s_tuser   = '0;   // operation[1:0]
	logic [39:0]       s_tdata   = '0;   // trans_id[31:0], msg_type[39:32]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [39:0]       m_tdata;          // id_out[31:0], status[33:32],
	                                     // is_active[34], type_matches[35]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ID_W-1:0]   cfg_data  = '0;   // id_seed[31:0]

	// local copy of the table
	logic              held_valid [TABLE_DEPTH];
	logic [ID_W-1:0]   held_id    [TABLE_DEPTH];
	logic [TYPE_W-1:0] held_type  [TABLE_DEPTH];
	logic [ID_W-1:0]   next_cand;

	track_result_t     pending_results [$];
	track_result_t     want;
	stim_row_t         dir_rows [DIR_ROWS];
	int                err_count  = 0;
	int                ready_hold = 0;
	int                burst_left = 0;

	transaction_id_tracker #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("FAIL transaction_id_tracker");
		$finish;
	end

	function automatic int slot_of(logic [ID_W-1:0] id);
		int i;
		int s;
		s = -1;
		for (i = 0; i < TABLE_DEPTH; i++)
			if (s < 0 && held_valid[i] && held_id[i] == id) s = i;
		return s;
	endfunction

	function automatic track_result_t track_step(op_t op, logic [ID_W-1:0] id,
			logic [TYPE_W-1:0] ty);
		track_result_t r;
		int slot;
		int i;
		int probes;
		logic [ID_W-1:0] probe;
		r.id_out    = id;
		r.status    = STAT_OK;
		r.id_active = 1'b0;
		r.type_hit  = 1'b0;
		if (op == OP_ADD) begin
			slot = -1;
			for (i = TABLE_DEPTH - 1; i >= 0; i--)
				if (!held_valid[i]) slot = i;
			if (slot < 0) begin
				r.id_out = '0;
				r.status = STAT_FULL;
			end else begin
				// step past held ids, wrapping at the top of the range
				probe  = next_cand;
				probes = 0;
				while (probes <= TABLE_DEPTH && slot_of(probe) >= 0) begin
					probe = probe + ID_W'(1);
					probes++;
				end
				next_cand        = probe;
				held_valid[slot] = 1'b1;
				held_id[slot]    = probe;
				held_type[slot]  = ty;
				r.id_out         = probe;
			end
		end else begin
			slot = slot_of(id);
			if (slot >= 0) begin
				r.id_active = 1'b1;
				r.type_hit  = (held_type[slot] == ty);
			end
			if (op == OP_VALIDATE) begin
				if (r.type_hit) held_valid[slot] = 1'b0;
				else r.status = STAT_NOPEND;
			end else if (op == OP_REMOVE && slot >= 0) begin
				held_valid[slot] = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [TYPE_W-1:0] ty,
			logic typed, track_result_t lit);
		track_result_t r;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ty, id};
		do @(posedge clk); while (!s_tready);
		r = track_step(op, id, ty);
		if (typed) r = lit;
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic send_random(int add_pct);
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [TYPE_W-1:0] ty;
		int                held [$];
		int                pick;
		int                i;
		for (i = 0; i < TABLE_DEPTH; i++)
			if (held_valid[i]) held.insert(held.size(), i);
		op = ($urandom_range(99) < add_pct) ? OP_ADD : op_t'($urandom_range(1, 3));
		id = $urandom;
		ty = TYPE_W'($urandom_range(255));
		// mostly aim at held ids, sometimes a neighbor one bit away
		if (held.size() != 0 && $urandom_range(99) < 85) begin
			pick = held[$urandom_range(held.size() - 1)];
			id   = held_id[pick];
			if ($urandom_range(9) == 0) id = id ^ (32'd1 << $urandom_range(31));
			if ($urandom_range(99) < 60) ty = held_type[pick];
		end
		send_word(op, id, ty, 1'b0, '0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(logic [ID_W-1:0] seed);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		next_cand = seed;
	endtask

	task automatic check_field(string name, logic [ID_W-1:0] exp_val,
			logic [ID_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name,
				exp_val, got_val);
			err_count++;
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_hold = $urandom_range(1, 30);
			m_tready <= ($urandom_range(2) != 0);
		end else begin
			ready_hold--;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual %h",
					$time, m_tdata);
				err_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("id_out", want.id_out, m_tdata[31:0]);
				check_field("status", 32'(want.status), 32'(m_tdata[33:32]));
				check_field("is_active", 32'(want.id_active), 32'(m_tdata[34]));
				check_field("type_matches", 32'(want.type_hit), 32'(m_tdata[35]));
			end
		end
	end

	initial begin
		logic [ID_W-1:0] seeds [PHASES];
		int              add_pct [PHASES];
		int              k;
		int              p;
		for (k = 0; k < TABLE_DEPTH; k++) held_valid[k] = 1'b0;
		next_cand = '0;
		seeds     = '{32'hFFFF_FFFE, 32'h0000_0000, $urandom, 32'hFFFF_FFFF, $urandom};
		add_pct   = '{55, 30, 70, 45, 25};
		// empty table, reset seed of zero
		dir_rows = '{
			'{OP_LOOKUP,   32'h0000_0000, 8'h00, 1,  1'b1,
				'{32'h0000_0000, STAT_OK,     1'b0, 1'b0}},
			'{OP_VALIDATE, 32'hFFFF_FFFF, 8'hFF, 1,  1'b1,
				'{32'hFFFF_FFFF, STAT_NOPEND, 1'b0, 1'b0}},
			'{OP_REMOVE,   32'h1234_5678, 8'h5A, 1,  1'b1,
				'{32'h1234_5678, STAT_OK,     1'b0, 1'b0}},
			'{OP_ADD,      32'hFFFF_FFFF, 8'hAB, 1,  1'b1,
				'{32'h0000_0000, STAT_OK,     1'b0, 1'b0}},
			'{OP_ADD,      32'h0000_0000, 8'h00, 1,  1'b0, '0},
			'{OP_LOOKUP,   32'h0000_0000, 8'hAB, 1,  1'b0, '0},
			'{OP_VALIDATE, 32'h0000_0000, 8'h01, 1,  1'b0, '0},
			'{OP_VALIDATE, 32'h0000_0000, 8'hAB, 1,  1'b0, '0},
			'{OP_REMOVE,   32'h0000_0001, 8'hFF, 1,  1'b0, '0},
			'{OP_ADD,      32'hA5A5_A5A5, 8'hFF, 16, 1'b0, '0},
			'{OP_ADD,      32'h5A5A_5A5A, 8'h11, 1,  1'b1,
				'{32'h0000_0000, STAT_FULL,   1'b0, 1'b0}},
			'{OP_LOOKUP,   32'h0000_0010, 8'hFF, 1,  1'b0, '0},
			'{OP_REMOVE,   32'h0000_0007, 8'hFF, 1,  1'b0, '0},
			'{OP_ADD,      32'h0000_0000, 8'h22, 1,  1'b0, '0},
			'{OP_VALIDATE, 32'h0000_0011, 8'h22, 1,  1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			repeat (dir_rows[k].reps)
				send_word(dir_rows[k].op, dir_rows[k].id, dir_rows[k].ty,
					dir_rows[k].typed, dir_rows[k].lit);

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			write_seed(seeds[p]);
			repeat (RAND_WORDS) send_random(add_pct[p]);
		end

		drain_results();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS transaction_id_tracker");
		end else begin
			$display("FAIL transaction_id_tracker");
		end
		$finish;
	end

endmodule
